// ===== hw/rtl/dqe_pkg.sv =====
// dqe_pkg: sizes, operation and status codes and cell commands for the
// double-ended queue. No dependencies; used by every other file.
`timescale 1ns / 1ps
`default_nettype none

package dqe_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int COUNT_W    = $clog2(DEPTH + 1);

  localparam int FUNC_W     = 3;
  localparam int DIN_W      = 32;
  localparam int DOUT_W     = 32;
  localparam int STATUS_W   = 2;
  localparam int ECOUNT_W   = 5;

  typedef logic [DATA_WIDTH-1:0] word_t;
  typedef logic [COUNT_W-1:0]    count_t;
  typedef logic [IDX_W-1:0]      idx_t;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUSH_FRONT = 3'd0,
    FUNC_PUSH_BACK  = 3'd1,
    FUNC_POP_FRONT  = 3'd2,
    FUNC_POP_BACK   = 3'd3,
    FUNC_PEEK_FRONT = 3'd4,
    FUNC_PEEK_BACK  = 3'd5
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD       = 2'd0,
    CELL_FROM_LEFT  = 2'd1,
    CELL_FROM_RIGHT = 2'd2,
    CELL_LOAD       = 2'd3
  } cell_cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/dqe_if.sv =====
// dqe_req_if and dqe_rsp_if: valid/ready channels of the double-ended queue
// depends on dqe_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface dqe_req_if;
  import dqe_pkg::*;

  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [DIN_W-1:0]  data_in;

  modport source (output valid, output func, output data_in, input ready);
  modport sink   (input valid, input func, input data_in, output ready);
endinterface

interface dqe_rsp_if;
  import dqe_pkg::*;

  logic                valid;
  logic                ready;
  logic [DOUT_W-1:0]   data_out;
  logic [STATUS_W-1:0] status;
  logic                is_empty;
  logic [ECOUNT_W-1:0] entry_count;

  modport source (output valid, output data_out, output status, output is_empty,
                  output entry_count, input ready);
  modport sink   (input valid, input data_out, input status, input is_empty,
                  input entry_count, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/double_ended_queue.sv =====
// double_ended_queue: top level, a chain of dqe_cell storage cells under dqe_ctrl
// depends on dqe_pkg, dqe_if.sv, dqe_cell and dqe_ctrl
//
//   port  dir   transaction payload
//   req   sink  func, data_in
//   rsp   src   data_out, status, is_empty, entry_count
//
// one transaction per cycle while req.ready is high
// the result is registered and appears the cycle after acceptance
// req.ready drops only while a result waits and rsp.ready is low
// rst clears the count and the result valid flag; cell contents are not cleared
// front entry sits in the first cell, pushes and pops at the front shift the chain
`timescale 1ns / 1ps
`default_nettype none

module double_ended_queue (
  input  wire        clk,
  input  wire        rst,
  dqe_req_if.sink    req,
  dqe_rsp_if.source  rsp
);
  import dqe_pkg::*;

  word_t     cell_word [DEPTH];
  cell_cmd_t cell_cmd  [DEPTH];
  word_t     load_word;

  dqe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .cell_word (cell_word),
    .cell_cmd  (cell_cmd),
    .load_word (load_word)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    word_t left_word;
    word_t right_word;

    if (i == 0) begin : g_first
      assign left_word = load_word;
    end else begin : g_inner_left
      assign left_word = cell_word[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_word = cell_word[i];
    end else begin : g_inner_right
      assign right_word = cell_word[i+1];
    end

    dqe_cell u_cell (
      .clk        (clk),
      .cmd        (cell_cmd[i]),
      .from_left  (left_word),
      .from_right (right_word),
      .load_word  (load_word),
      .word       (cell_word[i])
    );
  end

endmodule

`default_nettype wire

// ===== hw/rtl/dqe_cell.sv =====
// dqe_cell: one storage cell of the queue chain, shifts to either neighbour
// or loads the transaction word; depends on dqe_pkg
`timescale 1ns / 1ps
`default_nettype none

module dqe_cell (
  input  wire                 clk,
  input  dqe_pkg::cell_cmd_t  cmd,
  input  dqe_pkg::word_t      from_left,
  input  dqe_pkg::word_t      from_right,
  input  dqe_pkg::word_t      load_word,
  output dqe_pkg::word_t      word
);
  import dqe_pkg::*;

  always_ff @(posedge clk) begin
    case (cmd)
      CELL_FROM_LEFT:  word <= from_left;
      CELL_FROM_RIGHT: word <= from_right;
      CELL_LOAD:       word <= load_word;
      default:         word <= word;
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/dqe_ctrl.sv =====
// dqe_ctrl: operation decode, entry count, cell commands and result register
// depends on dqe_pkg and the channel interfaces in dqe_if.sv
`timescale 1ns / 1ps
`default_nettype none

module dqe_ctrl (
  input  wire                clk,
  input  wire                rst,
  dqe_req_if.sink            req,
  dqe_rsp_if.source          rsp,
  input  dqe_pkg::word_t     cell_word [dqe_pkg::DEPTH],
  output dqe_pkg::cell_cmd_t cell_cmd  [dqe_pkg::DEPTH],
  output dqe_pkg::word_t     load_word
);
  import dqe_pkg::*;

  count_t  held_count;
  count_t  held_count_next;
  count_t  back_slot;
  idx_t    back_idx;
  idx_t    push_idx;
  word_t   back_word;
  word_t   read_next;
  status_t status_next;
  status_t status;
  word_t   read_word;
  logic    out_valid;
  logic    fire;
  logic    full;
  logic    empty;

  assign req.ready = !out_valid || rsp.ready;
  assign fire      = req.valid && req.ready;
  assign load_word = word_t'(req.data_in);
  assign full      = held_count == COUNT_W'(DEPTH);
  assign empty     = held_count == '0;
  assign back_slot = held_count - COUNT_W'(1);
  assign back_idx  = back_slot[IDX_W-1:0];
  assign push_idx  = held_count[IDX_W-1:0];

  // back entry picked by a one-hot match across the chain
  always_comb begin
    back_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (back_idx == IDX_W'(i)) begin
        back_word = back_word | cell_word[i];
      end
    end
  end

  always_comb begin
    held_count_next = held_count;
    status_next     = STATUS_OK;
    read_next       = '0;
    for (int i = 0; i < DEPTH; i++) begin
      cell_cmd[i] = CELL_HOLD;
    end
    if (fire) begin
      case (func_t'(req.func))
        FUNC_PUSH_FRONT: begin
          if (full) begin
            status_next = STATUS_FULL;
          end else begin
            for (int i = 0; i < DEPTH; i++) begin
              cell_cmd[i] = CELL_FROM_LEFT;
            end
            held_count_next = held_count + COUNT_W'(1);
          end
        end
        FUNC_PUSH_BACK: begin
          if (full) begin
            status_next = STATUS_FULL;
          end else begin
            for (int i = 0; i < DEPTH; i++) begin
              if (push_idx == IDX_W'(i)) begin
                cell_cmd[i] = CELL_LOAD;
              end
            end
            held_count_next = held_count + COUNT_W'(1);
          end
        end
        FUNC_POP_FRONT: begin
          if (empty) begin
            status_next = STATUS_EMPTY;
          end else begin
            read_next = cell_word[0];
            for (int i = 0; i < DEPTH; i++) begin
              cell_cmd[i] = CELL_FROM_RIGHT;
            end
            held_count_next = back_slot;
          end
        end
        FUNC_POP_BACK: begin
          if (empty) begin
            status_next = STATUS_EMPTY;
          end else begin
            read_next       = back_word;
            held_count_next = back_slot;
          end
        end
        FUNC_PEEK_FRONT: begin
          if (empty) begin
            status_next = STATUS_EMPTY;
          end else begin
            read_next = cell_word[0];
          end
        end
        FUNC_PEEK_BACK: begin
          if (empty) begin
            status_next = STATUS_EMPTY;
          end else begin
            read_next = back_word;
          end
        end
        default: begin
          status_next = STATUS_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      held_count <= held_count_next;
      if (fire) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      read_word <= read_next;
      status    <= status_next;
    end
  end

  // count reported is the one held after the transaction, valid until taken
  assign rsp.valid       = out_valid;
  assign rsp.data_out    = DOUT_W'(read_word);
  assign rsp.status      = status;
  assign rsp.is_empty    = held_count == '0;
  assign rsp.entry_count = ECOUNT_W'(held_count);

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    held_count <= COUNT_W'(DEPTH))
    else $error("entry count above depth");

  a_full_only_when_full: assert property (@(posedge clk) disable iff (rst)
    fire |=> (status != STATUS_FULL || held_count == COUNT_W'(DEPTH)))
    else $error("full error reported below depth");

  a_empty_only_when_empty: assert property (@(posedge clk) disable iff (rst)
    fire |=> (status != STATUS_EMPTY || held_count == '0))
    else $error("empty error reported with entries held");

  a_pop_front_count: assert property (@(posedge clk) disable iff (rst)
    (fire && func_t'(req.func) == FUNC_POP_FRONT && !empty)
      |=> held_count == $past(held_count) - COUNT_W'(1))
    else $error("pop front did not drop the count");

  a_count_held_while_stalled: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !rsp.ready) |=> $stable(held_count))
    else $error("count moved while result stalled");

endmodule

`default_nettype wire
